@@ sv/crg_pkg.sv @@
`default_nettype none

package crg_pkg;

  // Row fields are fixed at 12 bits.
  localparam int unsigned ROW_BITS   = 12;
  localparam int unsigned MARGIN_W   = 10;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  // Signed working width for the window math: covers +/- (3 * row max).
  localparam int unsigned CALC_W     = ROW_BITS + 4;

  localparam logic [ROW_BITS-1:0] ROW_MAX = {ROW_BITS{1'b1}};

  // Register reset values.
  localparam logic [MARGIN_W-1:0] RST_WINDOW_MARGIN     = MARGIN_W'(32);
  localparam logic [MARGIN_W-1:0] RST_MOVE_MARGIN       = MARGIN_W'(16);
  localparam logic [ROW_BITS-1:0] RST_MIN_WINDOW_HEIGHT = ROW_BITS'(256);
  localparam logic [COUNT_W-1:0]  RST_GAIN_HOLD_FRAMES  = COUNT_W'(100);
  localparam logic [COUNT_W-1:0]  RST_RESET_HOLD_FRAMES = COUNT_W'(25);
  localparam logic [ROW_BITS-1:0] RST_DEFAULT_OFFSET    = ROW_BITS'(0);
  localparam logic [ROW_BITS-1:0] RST_DEFAULT_HEIGHT    = ROW_MAX;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_MARGIN     = 3'd0,
    CFG_MOVE_MARGIN       = 3'd1,
    CFG_MIN_WINDOW_HEIGHT = 3'd2,
    CFG_GAIN_HOLD_FRAMES  = 3'd3,
    CFG_RESET_HOLD_FRAMES = 3'd4,
    CFG_DEFAULT_OFFSET    = 3'd5,
    CFG_DEFAULT_HEIGHT    = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic                     parse_ok;
    logic                     history_empty;
    logic [ROW_BITS-1:0]      joint_top;
    logic [ROW_BITS-1:0]      joint_bottom;
    logic [ROW_BITS-1:0]      frame_offset;
    logic [ROW_BITS-1:0]      frame_height;
    logic                     gain_suggested;
    logic signed [GAIN_W-1:0] gain_step;
  } in_word_t;

  typedef struct packed {
    logic                     set_window;
    logic [ROW_BITS-1:0]      window_offset;
    logic [ROW_BITS-1:0]      window_height;
    logic                     adjust_gain;
    logic signed [GAIN_W-1:0] gain_step_out;
    logic                     reset_window_gain;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_word_t;

endpackage

`default_nettype wire

@@ sv/crg_ifs.sv @@
`default_nettype none

interface crg_in_if;
  logic              valid;
  logic              ready;
  crg_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface crg_out_if;
  logic               valid;
  logic               ready;
  crg_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface crg_cfg_if;
  logic               valid;
  logic               ready;
  crg_pkg::cfg_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/camera_roi_and_gain_tracker.sv @@
// An accepted input word goes to the input reg, and its result word to the result reg.
// Throughput: one word per cycle unless out_o stalls; window math: one pass between regs.
// Config writes are accepted every cycle (ready tied high), one register per word.
// Reset (rst_ni low, async): pipeline empty, pending request cleared, frame counter 0,
// config registers back to their documented defaults.
`default_nettype none

module camera_roi_and_gain_tracker (
  input  wire        clk_i,
  input  wire        rst_ni,
  crg_in_if.sink     in_i,
  crg_out_if.source  out_o,
  crg_cfg_if.sink    cfg_i
);
  import crg_pkg::*;

  // ---------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------
  logic [MARGIN_W-1:0] window_margin_q, move_margin_q;
  logic [ROW_BITS-1:0] min_window_height_q, default_offset_q, default_height_q;
  logic [COUNT_W-1:0]  gain_hold_frames_q, reset_hold_frames_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_margin_q     <= RST_WINDOW_MARGIN;
      move_margin_q       <= RST_MOVE_MARGIN;
      min_window_height_q <= RST_MIN_WINDOW_HEIGHT;
      gain_hold_frames_q  <= RST_GAIN_HOLD_FRAMES;
      reset_hold_frames_q <= RST_RESET_HOLD_FRAMES;
      default_offset_q    <= RST_DEFAULT_OFFSET;
      default_height_q    <= RST_DEFAULT_HEIGHT;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.data.index))
        CFG_WINDOW_MARGIN:     window_margin_q     <= cfg_i.data.value[MARGIN_W-1:0];
        CFG_MOVE_MARGIN:       move_margin_q       <= cfg_i.data.value[MARGIN_W-1:0];
        CFG_MIN_WINDOW_HEIGHT: min_window_height_q <= cfg_i.data.value[ROW_BITS-1:0];
        CFG_GAIN_HOLD_FRAMES:  gain_hold_frames_q  <= cfg_i.data.value[COUNT_W-1:0];
        CFG_RESET_HOLD_FRAMES: reset_hold_frames_q <= cfg_i.data.value[COUNT_W-1:0];
        CFG_DEFAULT_OFFSET:    default_offset_q    <= cfg_i.data.value[ROW_BITS-1:0];
        CFG_DEFAULT_HEIGHT:    default_height_q    <= cfg_i.data.value[ROW_BITS-1:0];
        default: ;  // index outside the map: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Handshake: input reg -> result reg, both can hold a word.
  // The input reg drains whenever the result reg is empty or being taken.
  // ---------------------------------------------------------------
  logic      in_valid_q, out_valid_q;
  in_word_t  in_q;
  out_word_t out_q, res;
  logic      advance;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // ---------------------------------------------------------------
  // Tracker state
  // ---------------------------------------------------------------
  logic                pend_valid_q, pend_valid_d;
  logic [ROW_BITS-1:0] pend_offset_q, pend_offset_d;
  logic [ROW_BITS-1:0] pend_height_q, pend_height_d;
  logic [COUNT_W-1:0]  frames_q, frames_d;

  // ---------------------------------------------------------------
  // Window math, signed at CALC_W so differences never wrap.
  // ---------------------------------------------------------------
  logic signed [CALC_W-1:0] tp, bt, of, hg, wm, mm, mh;
  logic signed [CALC_W-1:0] span, top_edge, bot_edge, top_drift, bot_drift;
  logic signed [CALC_W-1:0] top_abs, bot_abs;
  logic signed [CALC_W-1:0] no_base, nh_base, shortfall, half, no_adj, nh_min, nh_sat;
  logic                     req_seen, covers, drift, short_win, changed;
  logic [ROW_BITS-1:0]      new_off, new_hgt;
  logic [COUNT_W-1:0]       frames_inc;
  logic                     do_gain, do_reset;

  always_comb begin
    tp = $signed({{(CALC_W-ROW_BITS){1'b0}}, in_q.joint_top});
    bt = $signed({{(CALC_W-ROW_BITS){1'b0}}, in_q.joint_bottom});
    of = $signed({{(CALC_W-ROW_BITS){1'b0}}, in_q.frame_offset});
    hg = $signed({{(CALC_W-ROW_BITS){1'b0}}, in_q.frame_height});
    wm = $signed({{(CALC_W-MARGIN_W){1'b0}}, window_margin_q});
    mm = $signed({{(CALC_W-MARGIN_W){1'b0}}, move_margin_q});
    mh = $signed({{(CALC_W-ROW_BITS){1'b0}}, min_window_height_q});

    // Nothing outstanding, or the frame shows the requested window.
    req_seen = !pend_valid_q ||
               (pend_offset_q == in_q.frame_offset && pend_height_q == in_q.frame_height);

    // Minimum-height window already holds the joint plus margins.
    span     = bt - tp + (wm <<< 1);
    top_edge = of + wm;
    bot_edge = bt + wm;
    covers   = (in_q.frame_height == min_window_height_q) && (span <= mh) &&
               (top_edge <= tp) && (bot_edge <= of + hg);

    top_drift = (tp - wm) - of;
    bot_drift = (bt + wm) - (of + hg);
    top_abs   = top_drift[CALC_W-1] ? -top_drift : top_drift;
    bot_abs   = bot_drift[CALC_W-1] ? -bot_drift : bot_drift;
    drift     = (top_abs > mm) || (bot_abs > mm);

    // New window: margin above top, grow to minimum height centered, clamp.
    no_base   = (tp > wm) ? tp - wm : '0;
    nh_base   = (bt - no_base) + wm;
    short_win = nh_base < mh;
    shortfall = mh - nh_base;           // positive whenever it is used
    half      = shortfall >>> 1;
    if (short_win) begin
      no_adj = (no_base > half) ? no_base - half : '0;
      nh_min = mh;
    end else begin
      no_adj = no_base;
      nh_min = nh_base;
    end
    nh_sat  = (nh_min > $signed({{(CALC_W-ROW_BITS){1'b0}}, ROW_MAX}))
              ? $signed({{(CALC_W-ROW_BITS){1'b0}}, ROW_MAX}) : nh_min;
    new_off = no_adj[ROW_BITS-1:0];
    new_hgt = nh_sat[ROW_BITS-1:0];
    changed = (new_off != in_q.frame_offset) || (new_hgt != in_q.frame_height);

    // Successful-frame counter, saturating.
    frames_inc = (frames_q != {COUNT_W{1'b1}}) ? frames_q + COUNT_W'(1) : frames_q;
    do_gain    = (frames_inc > gain_hold_frames_q) && in_q.gain_suggested;

    do_reset = !in_q.parse_ok && in_q.history_empty && !pend_valid_q &&
               (in_q.frame_offset != '0) && (frames_q > reset_hold_frames_q);

    // Defaults: state holds, result idle.
    pend_valid_d  = pend_valid_q;
    pend_offset_d = pend_offset_q;
    pend_height_d = pend_height_q;
    frames_d      = frames_q;
    res           = '0;

    if (in_q.parse_ok) begin
      if (req_seen) begin
        if (!covers && drift) begin
          if (changed) begin
            pend_valid_d      = 1'b1;
            pend_offset_d     = new_off;
            pend_height_d     = new_hgt;
            res.set_window    = 1'b1;
            res.window_offset = new_off;
            res.window_height = new_hgt;
          end
        end else begin
          pend_valid_d = 1'b0;   // settled window, drop the request
        end
      end
      frames_d = frames_inc;
      if (do_gain) begin
        res.adjust_gain   = 1'b1;
        res.gain_step_out = in_q.gain_step;
        frames_d          = '0;
      end
    end else if (do_reset) begin
      // Defaults go out and are tracked as the outstanding request.
      pend_valid_d          = 1'b1;
      pend_offset_d         = default_offset_q;
      pend_height_d         = default_height_q;
      res.reset_window_gain = 1'b1;
      res.window_offset     = default_offset_q;
      res.window_height     = default_height_q;
    end
  end

  // ---------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      pend_valid_q  <= 1'b0;
      pend_offset_q <= '0;
      pend_height_q <= '0;
      frames_q      <= '0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q   <= 1'b1;
        pend_valid_q  <= pend_valid_d;
        pend_offset_q <= pend_offset_d;
        pend_height_q <= pend_height_d;
        frames_q      <= frames_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
    if (advance) begin
      out_q <= res;
    end
  end

endmodule

`default_nettype wire

@@ sv/crg_checker.sv @@
`default_nettype none

module crg_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                out_valid,
  input wire                out_ready,
  input crg_pkg::out_word_t out_data
);
  import crg_pkg::*;

  // Stalled result word must hold.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Window fields are zero unless a window is requested or reset.
  a_idle_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data.set_window && !out_data.reset_window_gain |->
      out_data.window_offset == '0 && out_data.window_height == '0)
    else $error("window fields not idle");

  // Gain step is zero unless a gain adjust is issued.
  a_idle_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data.adjust_gain |-> out_data.gain_step_out == '0)
    else $error("gain step not idle");

  // A failure reset never comes with a window request or gain step.
  a_reset_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.reset_window_gain |->
      !out_data.set_window && !out_data.adjust_gain)
    else $error("reset mixed with success actions");

endmodule

bind camera_roi_and_gain_tracker crg_checker u_crg_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  (out_o.data)
);

`default_nettype wire
